### rtl/swf_pkg.sv
// ----------------------------------------------------------------------------
// swf_pkg
// Shared types, constants and the move table for the wall-follow controller.
// ----------------------------------------------------------------------------
package swf_pkg;

  // Default parameter values.
  localparam int unsigned MaxScanDefault  = 4096;
  localparam int unsigned DistBitsDefault = 16;

  // Fixed field widths.
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned ScanLenW = 13;
  localparam int unsigned TotalW   = 28;
  localparam int unsigned MoveW    = 3;
  localparam int unsigned AngW     = 10;
  localparam int unsigned LinW     = 9;
  localparam int unsigned OutDataW = 24;

  // Register reset values.
  localparam logic [ScanLenW-1:0] ScanLengthRst  = 13'd640;
  localparam logic [CfgDataW-1:0] SensorMaxRst   = 16'd10000;
  localparam logic [CfgDataW-1:0] SensorMinRst   = 16'd450;
  localparam logic [CfgDataW-1:0] NearWallRst    = 16'd500;
  localparam logic [CfgDataW-1:0] CrashRst       = 16'd250;
  localparam logic [CfgDataW-1:0] DoorOpenRst    = 16'd2000;
  localparam logic [CfgDataW-1:0] DoorEndRst     = 16'd500;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SCAN_LENGTH = 3'd0,
    REG_SENSOR_MAX  = 3'd1,
    REG_SENSOR_MIN  = 3'd2,
    REG_NEAR_WALL   = 3'd3,
    REG_CRASH       = 3'd4,
    REG_DOOR_OPEN   = 3'd5,
    REG_DOOR_END    = 3'd6
  } cfg_reg_e;

  typedef enum logic [MoveW-1:0] {
    MOVE_STOP       = 3'd0,
    MOVE_FORWARD    = 3'd1,
    MOVE_BACK       = 3'd2,
    MOVE_TURN_LEFT  = 3'd3,
    MOVE_TURN_RIGHT = 3'd4,
    MOVE_GO_LEFT    = 3'd5,
    MOVE_GO_RIGHT   = 3'd6
  } move_e;

  // One queued result: the move code and the end-of-scan marker.
  typedef struct packed {
    move_e move;
    logic  last;
  } result_t;

  function automatic logic signed [AngW-1:0] move_angular(input move_e m);
    logic signed [AngW-1:0] r;
    unique case (m)
      MOVE_TURN_LEFT:  r = 10'sd256;
      MOVE_TURN_RIGHT: r = -10'sd256;
      MOVE_GO_LEFT:    r = 10'sd64;
      MOVE_GO_RIGHT:   r = -10'sd64;
      default:         r = 10'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [LinW-1:0] move_linear(input move_e m);
    logic signed [LinW-1:0] r;
    unique case (m)
      MOVE_FORWARD:  r = 9'sd128;
      MOVE_BACK:     r = -9'sd128;
      MOVE_GO_LEFT:  r = 9'sd64;
      MOVE_GO_RIGHT: r = 9'sd64;
      default:       r = 9'sd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/scan_wall_follow_controller.sv
// ----------------------------------------------------------------------------
// scan_wall_follow_controller
// Tracks running statistics over a laser scan and issues wall-follow moves.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Carries
//  s_axis    | in        | tdata: distance_mm; tuser: invalid
//  m_axis    | out       | tdata: move, angular_rate, linear_speed; tlast: last
//  cfg       | in        | register index and 16-bit write data
//
// A sample is taken every unstalled cycle; its accumulator update lands at the
// accept edge. The last sample of a scan is decided in the next cycle and its
// one or two moves enter a four-entry result queue feeding m_axis. The input
// stalls only while the queue could not hold the moves of another scan end.
// Reset clears the tracker state, the queue and the registers to defaults.
// ----------------------------------------------------------------------------
module scan_wall_follow_controller #(
  parameter int unsigned MAX_SCAN  = swf_pkg::MaxScanDefault,
  parameter int unsigned DIST_BITS = swf_pkg::DistBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // distance_mm in the low DIST_BITS bits, zero filled above
  input  logic [((DIST_BITS+7)/8)*8-1:0]         s_axis_tdata,
  // invalid
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // move [2:0], angular_rate [12:3], linear_speed [21:13], zero above
  output logic [swf_pkg::OutDataW-1:0]           m_axis_tdata,
  output logic                                   m_axis_tlast,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [swf_pkg::CfgAddrW-1:0]           cfg_addr_i,
  input  logic [swf_pkg::CfgDataW-1:0]           cfg_data_i
);

  localparam int unsigned CmpW  = (DIST_BITS > swf_pkg::CfgDataW) ? DIST_BITS
                                                                  : swf_pkg::CfgDataW;
  localparam int unsigned NW    = swf_pkg::ScanLenW;
  localparam int unsigned TotW  = swf_pkg::TotalW;
  localparam int unsigned QDepth = 4;

  // Configuration registers.
  logic [NW-1:0]               scan_len_q;
  logic [swf_pkg::CfgDataW-1:0] sensor_max_q, sensor_min_q, near_wall_q;
  logic [swf_pkg::CfgDataW-1:0] crash_q, door_open_q, door_end_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_len_q   <= swf_pkg::ScanLengthRst;
      sensor_max_q <= swf_pkg::SensorMaxRst;
      sensor_min_q <= swf_pkg::SensorMinRst;
      near_wall_q  <= swf_pkg::NearWallRst;
      crash_q      <= swf_pkg::CrashRst;
      door_open_q  <= swf_pkg::DoorOpenRst;
      door_end_q   <= swf_pkg::DoorEndRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        swf_pkg::REG_SCAN_LENGTH: scan_len_q   <= cfg_data_i[NW-1:0];
        swf_pkg::REG_SENSOR_MAX:  sensor_max_q <= cfg_data_i;
        swf_pkg::REG_SENSOR_MIN:  sensor_min_q <= cfg_data_i;
        swf_pkg::REG_NEAR_WALL:   near_wall_q  <= cfg_data_i;
        swf_pkg::REG_CRASH:       crash_q      <= cfg_data_i;
        swf_pkg::REG_DOOR_OPEN:   door_open_q  <= cfg_data_i;
        swf_pkg::REG_DOOR_END:    door_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective scan length, clamped to 1..MAX_SCAN.
  logic [NW-1:0] n_eff;
  always_comb begin
    if (scan_len_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(scan_len_q) > 32'(MAX_SCAN)) begin
      n_eff = NW'(MAX_SCAN);
    end else begin
      n_eff = scan_len_q;
    end
  end

  logic [NW-1:0] n_quarter, n_half;
  assign n_quarter = n_eff >> 2;
  assign n_half    = n_eff >> 1;

  // Tracker state.
  logic [NW-1:0]        idx_q, idx_d;
  logic [CmpW-1:0]      nearest_q, nearest_d;
  logic [CmpW-1:0]      farthest_q, farthest_d;
  logic [TotW-1:0]      left_tot_q, left_tot_d, right_tot_q, right_tot_d;
  logic                 left_bad_q, left_bad_d, right_bad_q, right_bad_d;
  logic [NW-1:0]        inv_cnt_q, inv_cnt_d;
  logic [DIST_BITS:0]   mid_q, mid_d, first_q, first_d;
  logic                 end_q;

  logic [DIST_BITS-1:0] din;
  logic                 bad;
  logic                 s_fire;
  logic                 is_last;
  logic [TotW:0]        tot_sum;

  assign din    = s_axis_tdata[DIST_BITS-1:0];
  assign bad    = s_axis_tuser;
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign is_last = (NW'(idx_q + NW'(1)) >= n_eff) || (idx_q == {NW{1'b1}});

  always_comb begin
    logic restart;
    logic [TotW-1:0] lt, rt;
    restart = (idx_q == '0);
    if (restart) begin
      nearest_d   = CmpW'(sensor_max_q);
      farthest_d  = CmpW'(sensor_min_q);
      lt          = '0;
      rt          = '0;
      left_bad_d  = 1'b0;
      right_bad_d = 1'b0;
      inv_cnt_d   = '0;
      mid_d       = '0;
      first_d     = '0;
    end else begin
      nearest_d   = nearest_q;
      farthest_d  = farthest_q;
      lt          = left_tot_q;
      rt          = right_tot_q;
      left_bad_d  = left_bad_q;
      right_bad_d = right_bad_q;
      inv_cnt_d   = inv_cnt_q;
      mid_d       = mid_q;
      first_d     = first_q;
    end

    if (!bad && (CmpW'(din) < nearest_d)) nearest_d = CmpW'(din);
    if (bad) inv_cnt_d = NW'(inv_cnt_d + NW'(1));
    if ((idx_q < n_quarter) && !bad && (CmpW'(din) > farthest_d)) begin
      farthest_d = CmpW'(din);
    end

    // Only one half sum moves per sample, so one adder serves both.
    tot_sum = {1'b0, (idx_q > n_half) ? lt : rt} + (TotW+1)'(din);
    left_tot_d  = lt;
    right_tot_d = rt;
    if (idx_q > n_half) begin
      if (bad) left_bad_d = 1'b1;
      else     left_tot_d = tot_sum[TotW] ? {TotW{1'b1}} : tot_sum[TotW-1:0];
    end else begin
      if (bad) right_bad_d = 1'b1;
      else     right_tot_d = tot_sum[TotW] ? {TotW{1'b1}} : tot_sum[TotW-1:0];
    end

    if (idx_q == n_half) mid_d   = {bad, din};
    if (restart)         first_d = {bad, din};

    idx_d = is_last ? '0 : NW'(idx_q + NW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      nearest_q   <= '0;
      farthest_q  <= '0;
      left_tot_q  <= '0;
      right_tot_q <= '0;
      left_bad_q  <= 1'b0;
      right_bad_q <= 1'b0;
      inv_cnt_q   <= '0;
      mid_q       <= '0;
      first_q     <= '0;
      end_q       <= 1'b0;
    end else begin
      end_q <= s_fire && is_last;
      if (s_fire) begin
        idx_q       <= idx_d;
        nearest_q   <= nearest_d;
        farthest_q  <= farthest_d;
        left_tot_q  <= left_tot_d;
        right_tot_q <= right_tot_d;
        left_bad_q  <= left_bad_d;
        right_bad_q <= right_bad_d;
        inv_cnt_q   <= inv_cnt_d;
        mid_q       <= mid_d;
        first_q     <= first_d;
      end
    end
  end

  // End-of-scan decision, in the cycle after the last sample is accepted.
  logic            follow_q, follow_d, door_q, door_d;
  logic [1:0]      n_push;
  swf_pkg::result_t push0, push1;

  always_comb begin
    logic [NW+3:0] inv_x10, n_x9;
    logic          crashed;
    logic          right_side;
    inv_x10 = ((NW+4)'(inv_cnt_q) << 3) + ((NW+4)'(inv_cnt_q) << 1);
    n_x9    = ((NW+4)'(n_eff) << 3) + (NW+4)'(n_eff);
    crashed = (inv_x10 > n_x9) ||
              (!mid_q[DIST_BITS] && (CmpW'(mid_q[DIST_BITS-1:0]) < CmpW'(crash_q)));
    right_side = !left_bad_q && !right_bad_q && (left_tot_q >= right_tot_q);

    follow_d = follow_q;
    door_d   = door_q;
    n_push   = 2'd0;
    push0    = '{move: swf_pkg::MOVE_STOP, last: 1'b0};
    push1    = '{move: swf_pkg::MOVE_STOP, last: 1'b1};

    if (end_q) begin
      if (crashed) begin
        n_push = 2'd1;
        push0  = '{move: swf_pkg::MOVE_BACK, last: 1'b1};
      end else if ((nearest_q <= CmpW'(near_wall_q)) && !door_q) begin
        follow_d = 1'b1;
        n_push   = 2'd2;
        push1    = '{move: right_side ? swf_pkg::MOVE_TURN_RIGHT
                                      : swf_pkg::MOVE_TURN_LEFT, last: 1'b1};
      end else begin
        if (follow_q && (farthest_q >= CmpW'(door_open_q))) begin
          door_d   = 1'b1;
          follow_d = 1'b0;
        end
        if (door_d) begin
          if (!first_q[DIST_BITS] &&
              (CmpW'(first_q[DIST_BITS-1:0]) <= CmpW'(door_end_q))) begin
            door_d = 1'b0;
            n_push = 2'd1;
            push0  = '{move: swf_pkg::MOVE_STOP, last: 1'b1};
          end else begin
            n_push = 2'd2;
            push1  = '{move: swf_pkg::MOVE_GO_RIGHT, last: 1'b1};
          end
        end else begin
          n_push = 2'd2;
          push1  = '{move: swf_pkg::MOVE_FORWARD, last: 1'b1};
        end
      end
    end
  end

  // Result queue; slot 0 drives the output.
  swf_pkg::result_t q_q [QDepth];
  swf_pkg::result_t q_d [QDepth];
  logic [2:0]       cnt_q, cnt_d;
  logic             pop;
  logic [2:0]       base;

  assign m_axis_tvalid = (cnt_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign base          = cnt_q - {2'b0, pop};
  assign cnt_d         = base + {1'b0, n_push};

  // Room for two moves per pending scan end, counting one still being decided.
  assign s_axis_tready = ({1'b0, cnt_q} + (end_q ? 4'd2 : 4'd0)) <= 4'd2;

  always_comb begin
    for (int j = 0; j < QDepth; j++) begin
      if (3'(j) < base) begin
        q_d[j] = (pop && (j + 1 < QDepth)) ? q_q[(j + 1) % QDepth] : q_q[j];
      end else if ((3'(j) == base) && (n_push != 2'd0)) begin
        q_d[j] = push0;
      end else if ((3'(j) == 3'(base + 3'd1)) && (n_push == 2'd2)) begin
        q_d[j] = push1;
      end else begin
        q_d[j] = q_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      follow_q <= 1'b0;
      door_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      follow_q <= follow_d;
      door_q   <= door_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QDepth; j++) begin
      q_q[j] <= q_d[j];
    end
  end

  assign m_axis_tdata = {2'b00,
                         swf_pkg::move_linear(q_q[0].move),
                         swf_pkg::move_angular(q_q[0].move),
                         q_q[0].move};
  assign m_axis_tlast = q_q[0].last;

endmodule

### tb/sv/scan_wall_follow_controller_tb.sv
// ----------------------------------------------------------------------------
// scan_wall_follow_controller_tb
// Self-checking testbench for the scan wall-follow controller.
//
// A short table of hand-picked scans covers crashes, wall turns with clean
// and poisoned halves, and entering and leaving door mode. Random scans
// follow under changing register settings, including scan length changes in
// the middle of a scan. The table fixes the moves of hand-picked scans and
// an internal tracker predicts those of random ones; each output item is
// compared with the oldest expected move. Stalls are random on both streams.
// ----------------------------------------------------------------------------
module scan_wall_follow_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ResetCycles  = 7;
  localparam int SettleCycles = 4;
  localparam int ScanMax      = swf_pkg::MaxScanDefault;
  localparam longint SumMax   = (64'd1 << swf_pkg::TotalW) - 1;
  localparam int TimeoutNs    = 4_000_000;

  typedef struct packed {
    swf_pkg::move_e                  mv;
    logic signed [swf_pkg::AngW-1:0] ang;
    logic signed [swf_pkg::LinW-1:0] lin;
    logic                            last;
  } move_item_t;

  // One directed step: a register write or a sample. A sample with
  // n_exp >= 0 carries its expected moves; n_exp < 0 defers to the tracker.
  typedef struct packed {
    bit                small_pad_unused_never;
  } unused_t;

  typedef struct packed {
    bit                is_cfg;
    swf_pkg::cfg_reg_e reg_id;
    logic [15:0]       value;
    logic              bad;
    int                n_exp;
    swf_pkg::move_e    m0;
    swf_pkg::move_e    m1;
  } dir_step_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [swf_pkg::OutDataW-1:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [swf_pkg::CfgAddrW-1:0] cfg_addr_i = '0;
  logic [swf_pkg::CfgDataW-1:0] cfg_data_i = '0;

  int send_idle_pct  = 12;
  int recv_stall_pct = 50;
  int mismatches     = 0;

  move_item_t pending_moves[$];

  // Register copies as written to the block.
  logic [swf_pkg::ScanLenW-1:0] len_reg = swf_pkg::ScanLengthRst;
  logic [15:0]         sensor_max_reg = swf_pkg::SensorMaxRst;
  logic [15:0]         sensor_min_reg = swf_pkg::SensorMinRst;
  logic [15:0]         near_reg       = swf_pkg::NearWallRst;
  logic [15:0]         crash_reg      = swf_pkg::CrashRst;
  logic [15:0]         door_open_reg  = swf_pkg::DoorOpenRst;
  logic [15:0]         door_end_reg   = swf_pkg::DoorEndRst;

  // Tracker state for the scan in progress.
  int          scan_pos      = 0;
  logic [15:0] nearest       = '0;
  logic [15:0] front_max     = '0;
  longint      left_sum      = 0;
  longint      right_sum     = 0;
  bit          left_bad      = 1'b0;
  bit          right_bad     = 1'b0;
  int          invalid_total = 0;
  logic [16:0] mid_tag       = '0;
  logic [16:0] first_tag     = '0;
  bit          wall_follow   = 1'b0;
  bit          door_flag     = 1'b0;

  dir_step_t dir_steps [26] = '{
    '{1'b1, swf_pkg::REG_SCAN_LENGTH, 16'd0, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    // Length zero acts as one: every sample ends a scan.
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd0, 1'b0, 1,
      swf_pkg::MOVE_BACK, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'hFFFF, 1'b0, 2,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_FORWARD},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'hFFFF, 1'b1, 1,
      swf_pkg::MOVE_BACK, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd300, 1'b0, 2,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_TURN_LEFT},
    '{1'b1, swf_pkg::REG_SCAN_LENGTH, 16'd4, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    // Invalid middle sample of zero is no crash; wide front opens a door.
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd3000, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd3000, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd0, 1'b1, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd3000, 1'b0, 2,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_GO_RIGHT},
    // An invalid first sample does not end door mode.
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd100, 1'b1, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd3000, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd3000, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd3000, 1'b0, 2,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_GO_RIGHT},
    // A close first sample ends door mode with a lone stop.
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd400, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd3000, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd3000, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd3000, 1'b0, 1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd100, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd100, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd300, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd60000, 1'b0, 2,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_TURN_RIGHT},
    // Same scan with the left half poisoned turns the other way.
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd100, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd100, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd300, 1'b0, -1,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP},
    '{1'b0, swf_pkg::REG_SCAN_LENGTH, 16'd60000, 1'b1, 2,
      swf_pkg::MOVE_STOP, swf_pkg::MOVE_TURN_LEFT}
  };

  scan_wall_follow_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > ScanMax) return ScanMax;
    return int'(len_reg);
  endfunction

  function automatic logic [15:0] pick16(input int lo, input int hi);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, what);
  endtask

  task automatic push_move(input swf_pkg::move_e m, input logic last);
    move_item_t it;
    it.mv   = m;
    it.last = last;
    it.ang  = '0;
    it.lin  = '0;
    case (m)
      swf_pkg::MOVE_FORWARD:    it.lin = 9'sd128;
      swf_pkg::MOVE_BACK:       it.lin = -9'sd128;
      swf_pkg::MOVE_TURN_LEFT:  it.ang = 10'sd256;
      swf_pkg::MOVE_TURN_RIGHT: it.ang = -10'sd256;
      swf_pkg::MOVE_GO_LEFT:    begin it.ang = 10'sd64;  it.lin = 9'sd64; end
      swf_pkg::MOVE_GO_RIGHT:   begin it.ang = -10'sd64; it.lin = 9'sd64; end
      default:                  ;
    endcase
    pending_moves.push_back(it);
  endtask

  // Advances the scan tracker by one sample; at a scan end the moves are
  // queued when keep is set.
  task automatic track_sample(input logic [15:0] d, input logic bad, input bit keep);
    int  n;
    int  i;
    bit  crashed;
    bit  steer_right;
    n = eff_len();
    if (scan_pos == 0) begin
      nearest       = sensor_max_reg;
      front_max     = sensor_min_reg;
      left_sum      = 0;
      right_sum     = 0;
      left_bad      = 1'b0;
      right_bad     = 1'b0;
      invalid_total = 0;
      mid_tag       = '0;
      first_tag     = '0;
    end
    i = scan_pos;
    if (!bad && d < nearest) nearest = d;
    if (bad) invalid_total++;
    if (i < n / 4 && !bad && d > front_max) front_max = d;
    if (i > n / 2) begin
      if (bad) left_bad = 1'b1;
      else left_sum = (left_sum + d > SumMax) ? SumMax : left_sum + d;
    end else begin
      if (bad) right_bad = 1'b1;
      else right_sum = (right_sum + d > SumMax) ? SumMax : right_sum + d;
    end
    if (i == n / 2) mid_tag = {bad, d};
    if (i == 0) first_tag = {bad, d};

    if (i + 1 < n) begin
      scan_pos = i + 1;
    end else begin
      scan_pos = 0;
      crashed = (invalid_total * 10 > n * 9) ||
                (!mid_tag[16] && mid_tag[15:0] < crash_reg);
      if (crashed) begin
        if (keep) push_move(swf_pkg::MOVE_BACK, 1'b1);
      end else if (nearest <= near_reg && !door_flag) begin
        wall_follow = 1'b1;
        steer_right = !left_bad && !right_bad && left_sum >= right_sum;
        if (keep) begin
          push_move(swf_pkg::MOVE_STOP, 1'b0);
          push_move(steer_right ? swf_pkg::MOVE_TURN_RIGHT : swf_pkg::MOVE_TURN_LEFT,
                    1'b1);
        end
      end else begin
        if (wall_follow && front_max >= door_open_reg) begin
          door_flag   = 1'b1;
          wall_follow = 1'b0;
        end
        if (door_flag && !first_tag[16] && first_tag[15:0] <= door_end_reg) begin
          door_flag = 1'b0;
          if (keep) push_move(swf_pkg::MOVE_STOP, 1'b1);
        end else if (keep) begin
          push_move(swf_pkg::MOVE_STOP, 1'b0);
          push_move(door_flag ? swf_pkg::MOVE_GO_RIGHT : swf_pkg::MOVE_FORWARD, 1'b1);
        end
      end
    end
  endtask

  task automatic send_sample(input logic [15:0] d, input logic bad, input int n_exp,
                             input swf_pkg::move_e m0, input swf_pkg::move_e m1);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= bad;
    do @(posedge clk_i); while (!s_axis_tready);
    track_sample(d, bad, n_exp < 0);
    if (n_exp == 1) begin
      push_move(m0, 1'b1);
    end else if (n_exp == 2) begin
      push_move(m0, 1'b0);
      push_move(m1, 1'b1);
    end
  endtask

  // Holds the input until every queued move has come out, then lets the
  // decision stage of a scan still in flight settle.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input swf_pkg::cfg_reg_e r, input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= r;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (r)
      swf_pkg::REG_SCAN_LENGTH: len_reg        = v[swf_pkg::ScanLenW-1:0];
      swf_pkg::REG_SENSOR_MAX:  sensor_max_reg = v;
      swf_pkg::REG_SENSOR_MIN:  sensor_min_reg = v;
      swf_pkg::REG_NEAR_WALL:   near_reg       = v;
      swf_pkg::REG_CRASH:       crash_reg      = v;
      swf_pkg::REG_DOOR_OPEN:   door_open_reg  = v;
      swf_pkg::REG_DOOR_END:    door_end_reg   = v;
      default:                  ;
    endcase
  endtask

  // Random scan content, shaped so that wall, open and crash scans all
  // occur under the current thresholds.
  task automatic send_scan(input int count);
    int          n;
    int          kind;
    int          nan_pct;
    int          near_hi;
    int          far_lo;
    logic [15:0] d;
    logic        bad;
    n    = eff_len();
    kind = $urandom_range(0, 3);
    case ($urandom_range(0, 6))
      0, 1, 2: nan_pct = 0;
      3:       nan_pct = 5;
      4:       nan_pct = 30;
      5:       nan_pct = 95;
      default: nan_pct = 100;
    endcase
    near_hi = (near_reg > 65335) ? 65535 : near_reg + 200;
    far_lo  = (near_reg >= crash_reg) ? near_reg + 1 : crash_reg;
    if (far_lo > 65535) far_lo = 65535;
    for (int k = 0; k < count; k++) begin
      bad = ($urandom_range(0, 99) < nan_pct);
      case (kind)
        0:       d = 16'($urandom_range(0, near_hi));
        1:       d = 16'($urandom_range(far_lo, 65535));
        2:       d = 16'($urandom_range(0, 1) ? $urandom_range(0, near_hi)
                                              : $urandom_range(far_lo, 65535));
        default: d = 16'($urandom);
      endcase
      if (k == n / 2 && $urandom_range(0, 99) < 85) begin
        bad = 1'b0;
        d   = 16'($urandom_range(crash_reg, 65535));
      end
      if (k == 0 && $urandom_range(0, 99) < 30) begin
        bad = 1'b0;
        d   = 16'($urandom_range(0, door_end_reg));
      end
      send_sample(d, bad, -1, swf_pkg::MOVE_STOP, swf_pkg::MOVE_STOP);
    end
  endtask

  always @(posedge clk_i) begin : out_check
    move_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_moves.size() == 0) begin
        note_mismatch($sformatf("unexpected item: move %0d last %0b",
                                m_axis_tdata[2:0], m_axis_tlast));
      end else begin
        want = pending_moves.pop_front();
        if (m_axis_tdata[2:0] !== want.mv || m_axis_tdata[12:3] !== want.ang ||
            m_axis_tdata[21:13] !== want.lin || m_axis_tlast !== want.last) begin
          note_mismatch($sformatf(
              "move exp %0d got %0d, ang exp %0d got %0d, lin exp %0d got %0d, last exp %0b got %0b",
              want.mv, m_axis_tdata[2:0], want.ang, $signed(m_axis_tdata[12:3]),
              want.lin, $signed(m_axis_tdata[21:13]), want.last, m_axis_tlast));
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin : stimulus
    logic [15:0] len;
    int          n;
    int          sent;
    int          budget;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < 26; r++) begin
      if (dir_steps[r].is_cfg) begin
        wait_drain();
        write_reg(dir_steps[r].reg_id, dir_steps[r].value);
        cfg_valid_i <= 1'b0;
      end else begin
        send_sample(dir_steps[r].value, dir_steps[r].bad, dir_steps[r].n_exp,
                    dir_steps[r].m0, dir_steps[r].m1);
      end
    end

    for (int stage = 0; stage < 3; stage++) begin
      send_idle_pct  = (stage == 0) ? 12 : (stage == 1) ? 50 : 0;
      recv_stall_pct = (stage == 0) ? 50 : (stage == 1) ? 12 : 0;
      for (int ph = 0; ph < 4; ph++) begin
        wait_drain();
        case ($urandom_range(0, 9))
          0:       len = 16'd1;
          1:       len = 16'd0;
          2, 3:    len = 16'($urandom_range(17, 64));
          default: len = 16'($urandom_range(2, 16));
        endcase
        write_reg(swf_pkg::REG_SCAN_LENGTH, len);
        write_reg(swf_pkg::REG_SENSOR_MAX, pick16(3000, 65535));
        write_reg(swf_pkg::REG_SENSOR_MIN, pick16(0, 3000));
        write_reg(swf_pkg::REG_NEAR_WALL, pick16(0, 3000));
        write_reg(swf_pkg::REG_CRASH, pick16(0, 1000));
        write_reg(swf_pkg::REG_DOOR_OPEN, pick16(0, 20000));
        write_reg(swf_pkg::REG_DOOR_END, pick16(0, 3000));
        cfg_valid_i <= 1'b0;

        n      = eff_len();
        budget = (n > 32) ? n : 32;
        sent   = 0;
        while (sent < budget) begin
          send_scan(n);
          sent += n;
          if (ph == 1 && sent == n) wait_drain();
        end
        // Leave a scan unfinished so the next length change lands mid-scan.
        if (n > 1 && $urandom_range(0, 1) == 1) send_scan($urandom_range(1, n - 1));
      end
    end

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
rtl/swf_pkg.sv
rtl/scan_wall_follow_controller.sv
tb/sv/scan_wall_follow_controller_tb.sv
